>>> design/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the trigger.
`define ASSERT_SAME(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error("assertion failed");

// Check that the consequent holds in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error("assertion failed");

// Check that at most one bit of a command vector is set.
`define ASSERT_ONEHOT0(label, clk, rst_n, vec) \
	label: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(vec)) \
		else $error("assertion failed");

`endif

>>> design/pimc_pkg.sv
package pimc_pkg;

	localparam int CNT_W      = 16;
	localparam int TICK_W     = 24;
	localparam int DUTY_W     = 7;
	localparam int PER_W      = CNT_W + 1;
	localparam int DIV_STEPS  = TICK_W;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS);

	localparam logic [TICK_W-1:0] TICK_HZ_RESET = TICK_W'(1000000);
	localparam logic [TICK_W-1:0] DUTY_SCALE    = TICK_W'(100);

	typedef struct packed {
		logic             edge_rising;
		logic [CNT_W-1:0] capture_time;
	} cap_word_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty_percent;
		logic [TICK_W-1:0] frequency_hz;
		logic [CNT_W-1:0]  high_ticks;
		logic [CNT_W-1:0]  low_ticks;
		logic              zero_period;
	} res_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap_rise;
		logic cap_fall;
		logic cap_end;
		logic prep;
		logic step;
		logic load_out;
	} cmd_t;

endpackage

>>> design/pimc_ctrl.sv
`include "assert_macros.svh"

module pimc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cap_valid,
	input  logic            edge_rising,
	output logic            cap_stall,
	output logic            res_valid,
	input  logic            res_stall,
	output pimc_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_RISE,
		ST_FALL,
		ST_RISE2,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                             state_q;
	logic [pimc_pkg::STEP_CNT_W-1:0]    step_cnt_q;
	logic                               res_valid_q;
	logic                               accept;
	logic                               last_step;

	assign cap_stall = !(state_q == ST_RISE || state_q == ST_FALL || state_q == ST_RISE2);
	assign accept    = cap_valid && !cap_stall;
	assign last_step = step_cnt_q == pimc_pkg::STEP_CNT_W'(pimc_pkg::DIV_STEPS - 1);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.cap_rise = accept && state_q == ST_RISE && edge_rising;
		cmd.cap_fall = accept && state_q == ST_FALL && !edge_rising;
		cmd.cap_end  = accept && state_q == ST_RISE2 && edge_rising;
		cmd.prep     = state_q == ST_PREP;
		cmd.step     = state_q == ST_DIV;
		cmd.load_out = state_q == ST_DONE && (!res_valid_q || !res_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RISE;
			step_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_RISE: begin
					if (cmd.cap_rise) begin
						state_q <= ST_FALL;
					end
				end
				ST_FALL: begin
					if (cmd.cap_fall) begin
						state_q <= ST_RISE2;
					end
				end
				ST_RISE2: begin
					if (cmd.cap_end) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					step_cnt_q <= '0;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					step_cnt_q <= step_cnt_q + 1'b1;
					if (last_step) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_RISE;
					end
				end
				default: begin
					state_q <= ST_RISE;
				end
			endcase

			if (cmd.load_out) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`ASSERT_NEXT(a_end_to_prep, clk, arst_n, cmd.cap_end, state_q == ST_PREP)
	`ASSERT_NEXT(a_div_done, clk, arst_n, state_q == ST_DIV && last_step, state_q == ST_DONE)
	`ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.load_out, res_valid_q)
	`ASSERT_ONEHOT0(a_cmd_onehot, clk, arst_n, cmd)

endmodule

>>> design/pimc_dp.sv
module pimc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pimc_pkg::TICK_W-1:0]   cfg_data,
	input  logic [pimc_pkg::CNT_W-1:0]    capture_time,
	input  pimc_pkg::cmd_t                cmd,
	output pimc_pkg::res_word_t           res
);

	logic [pimc_pkg::TICK_W-1:0] tick_hz_q;
	logic [pimc_pkg::CNT_W-1:0]  first_q;
	logic [pimc_pkg::CNT_W-1:0]  fall_q;
	logic [pimc_pkg::CNT_W-1:0]  high_q;
	logic [pimc_pkg::CNT_W-1:0]  low_q;
	logic [pimc_pkg::PER_W-1:0]  period_q;
	logic [pimc_pkg::TICK_W-1:0] dnum_q;
	logic [pimc_pkg::TICK_W-1:0] fnum_q;
	logic [pimc_pkg::PER_W-1:0]  drem_q;
	logic [pimc_pkg::PER_W-1:0]  frem_q;
	pimc_pkg::res_word_t         res_q;

	logic [pimc_pkg::PER_W:0]    dtrial;
	logic [pimc_pkg::PER_W:0]    ftrial;
	logic [pimc_pkg::PER_W:0]    per_ext;
	logic                        dge;
	logic                        fge;
	logic [pimc_pkg::PER_W:0]    ddiff;
	logic [pimc_pkg::PER_W:0]    fdiff;
	logic                        zero;

	// One restoring step per cycle for both quotients.
	assign per_ext = {1'b0, period_q};
	assign dtrial  = {drem_q, dnum_q[pimc_pkg::TICK_W-1]};
	assign ftrial  = {frem_q, fnum_q[pimc_pkg::TICK_W-1]};
	assign dge     = dtrial >= per_ext;
	assign fge     = ftrial >= per_ext;
	assign ddiff   = dtrial - per_ext;
	assign fdiff   = ftrial - per_ext;
	assign zero    = period_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_hz_q <= pimc_pkg::TICK_HZ_RESET;
			first_q   <= '0;
			fall_q    <= '0;
		end else begin
			if (cfg_we) begin
				tick_hz_q <= cfg_data;
			end
			if (cmd.cap_rise) begin
				first_q <= capture_time;
			end
			if (cmd.cap_fall) begin
				fall_q <= capture_time;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_end) begin
			high_q   <= fall_q - first_q;
			low_q    <= capture_time - fall_q;
			period_q <= {1'b0, fall_q - first_q} + {1'b0, capture_time - fall_q};
		end
		if (cmd.prep) begin
			dnum_q <= pimc_pkg::TICK_W'(high_q) * pimc_pkg::DUTY_SCALE;
			fnum_q <= tick_hz_q;
			drem_q <= '0;
			frem_q <= '0;
		end else if (cmd.step) begin
			dnum_q <= {dnum_q[pimc_pkg::TICK_W-2:0], dge};
			fnum_q <= {fnum_q[pimc_pkg::TICK_W-2:0], fge};
			drem_q <= dge ? ddiff[pimc_pkg::PER_W-1:0] : dtrial[pimc_pkg::PER_W-1:0];
			frem_q <= fge ? fdiff[pimc_pkg::PER_W-1:0] : ftrial[pimc_pkg::PER_W-1:0];
		end
		if (cmd.load_out) begin
			res_q.duty_percent <= zero ? '0 : dnum_q[pimc_pkg::DUTY_W-1:0];
			res_q.frequency_hz <= zero ? '0 : fnum_q;
			res_q.high_ticks   <= high_q;
			res_q.low_ticks    <= low_q;
			res_q.zero_period  <= zero;
		end
	end

	assign res = res_q;

endmodule

>>> design/pwm_input_capture_measure_core.sv
// PWM input measurement from captured edges.
// Capture channel (cap_valid / cap_stall / cap): one word per edge, with its
// polarity and the free-running counter value latched at that edge. The core
// looks for rising, falling, rising in turn and drops edges of the wrong polarity.
// Result channel (res_valid / res_stall / res): one word per full period with
// high and low ticks, duty in whole percent and frequency in hertz.
// Edges that only advance the search are taken without stall. The closing rising
// edge starts a 24-step shift-subtract division (duty and frequency side by
// side in one unit); cap_stall stays high from that edge until the result
// is handed to the output register.
// A result waiting under res_stall does not block the next edges: the output
// register holds it and the core keeps capturing; only a second finished
// result waits in the final step until the first one is taken.
// cfg_we / cfg_data write tick_hz; write it only while the core is idle.
// Reset (arst_n low) clears the search, the stored edge times and the result
// valid, and sets tick_hz to 1000000.
module pwm_input_capture_measure_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pimc_pkg::TICK_W-1:0]   cfg_data,
	input  logic                          cap_valid,
	output logic                          cap_stall,
	input  pimc_pkg::cap_word_t           cap,
	output logic                          res_valid,
	input  logic                          res_stall,
	output pimc_pkg::res_word_t           res
);

	// Command bundle from the sequencer to the datapath.
	pimc_pkg::cmd_t cmd;

	// Sequencer: edge search, division step count, result handshake.
	pimc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cap_valid   (cap_valid),
		.edge_rising (cap.edge_rising),
		.cap_stall   (cap_stall),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.cmd         (cmd)
	);

	// Datapath: edge times, differences, divider and output register.
	pimc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.capture_time (cap.capture_time),
		.cmd          (cmd),
		.res          (res)
	);

endmodule

>>> test/pimc_measure_checker.sv
// Watches the capture, result and tick_hz ports, predicts each measurement
// word and compares it with what the core hands out.
module pimc_measure_checker
	import pimc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [TICK_W-1:0] cfg_data,
	input  logic              cap_valid,
	input  logic              cap_stall,
	input  cap_word_t         cap,
	input  logic              res_valid,
	input  logic              res_stall,
	input  res_word_t         res,
	output int                mismatch_count,
	output int                pending_words
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {
		SEEK_RISE  = 2'd0,
		SEEK_FALL  = 2'd1,
		SEEK_CLOSE = 2'd2
	} seek_t;

	seek_t             seek;
	logic [CNT_W-1:0]  rise_at;
	logic [CNT_W-1:0]  fall_at;
	logic [TICK_W-1:0] tick_rate;
	res_word_t         period_q[$];
	int                fails;

	// Advance the edge search by one word; return 1 with the measurement
	// when the word closes a period.
	function automatic bit measure_edge(input cap_word_t w, output res_word_t m);
		logic [CNT_W-1:0]  hi;
		logic [CNT_W-1:0]  lo;
		logic [PER_W-1:0]  period;
		logic [TICK_W-1:0] scaled;
		m = '0;
		case (seek)
		SEEK_FALL: begin
			if (!w.edge_rising) begin
				fall_at = w.capture_time;
				seek    = SEEK_CLOSE;
			end
		end
		SEEK_CLOSE: begin
			if (w.edge_rising) begin
				hi     = fall_at - rise_at;
				lo     = w.capture_time - fall_at;
				period = PER_W'(hi) + PER_W'(lo);
				m.high_ticks = hi;
				m.low_ticks  = lo;
				if (period == '0) begin
					m.zero_period = 1'b1;
				end else begin
					scaled         = TICK_W'(hi) * DUTY_SCALE;
					m.duty_percent = DUTY_W'(scaled / TICK_W'(period));
					m.frequency_hz = tick_rate / TICK_W'(period);
				end
				seek = SEEK_RISE;
				return 1'b1;
			end
		end
		default: begin
			if (w.edge_rising) begin
				rise_at = w.capture_time;
				seek    = SEEK_FALL;
			end
		end
		endcase
		return 1'b0;
	endfunction

	task automatic note_failure(input string what, input res_word_t want, input res_word_t got);
		if (fails < 10) begin
			$display("%0t %s: duty %0d/%0d freq %0d/%0d high %0d/%0d low %0d/%0d zero %0d/%0d",
				$realtime, what, want.duty_percent, got.duty_percent,
				want.frequency_hz, got.frequency_hz, want.high_ticks, got.high_ticks,
				want.low_ticks, got.low_ticks, want.zero_period, got.zero_period);
		end
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_word_t want;
		res_word_t next_word;
		if (!arst_n) begin
			period_q.delete();
			seek      = SEEK_RISE;
			rise_at   = '0;
			fall_at   = '0;
			tick_rate = TICK_HZ_RESET;
			fails     = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (period_q.size() == 0) begin
					note_failure("unexpected word (exp/got)", '0, res);
				end else begin
					want = period_q.pop_front();
					if (res.duty_percent !== want.duty_percent ||
					    res.frequency_hz !== want.frequency_hz ||
					    res.high_ticks   !== want.high_ticks   ||
					    res.low_ticks    !== want.low_ticks    ||
					    res.zero_period  !== want.zero_period) begin
						note_failure("mismatch (exp/got)", want, res);
					end
				end
			end
			if (cap_valid && !cap_stall) begin
				if (measure_edge(cap, next_word))
					period_q.push_back(next_word);
			end
			if (cfg_we)
				tick_rate = cfg_data;
		end
		mismatch_count <= fails;
		pending_words  <= period_q.size();
	end

endmodule

>>> test/tb_pwm_input_capture_measure_core.sv
// Top of the PWM capture testbench: drives edge words and tick_hz writes,
// toggles backpressure on the result side, and reports the verdict that
// the checker's counts give.
module tb_pwm_input_capture_measure_core;
	timeunit 1ns;
	timeprecision 1ps;
	import pimc_pkg::*;

	// Idle cycles with no handshake on either channel before giving up.
	// Worst legal case: the long result hold-off, a long sender gap, a long
	// receiver stall, the division and the settle pause, taken many times over.
	localparam int WATCHDOG_LIMIT = 6000;
	// Cycles to let pass once nothing is pending.
	localparam int SETTLE_CYCLES  = 40;
	// Length of the one long result hold-off.
	localparam int HOLD_CYCLES    = 400;
	localparam int WORDS_PER_RUN  = 112;
	localparam int NUM_RUNS       = 6;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [TICK_W-1:0] cfg_data;
	logic              cap_valid;
	logic              cap_stall;
	cap_word_t         cap;
	logic              res_valid;
	logic              res_stall;
	res_word_t         res;

	int mismatch_count;
	int pending_words;
	int words_sent;

	// Knobs for the idle patterns of each run.
	bit send_gapless;
	bit recv_free;
	bit hold_req;
	bit hold_served;

	pwm_input_capture_measure_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.cap_valid (cap_valid),
		.cap_stall (cap_stall),
		.cap       (cap),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	pimc_measure_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.cap_valid      (cap_valid),
		.cap_stall      (cap_stall),
		.cap            (cap),
		.res_valid      (res_valid),
		.res_stall      (res_stall),
		.res            (res),
		.mismatch_count (mismatch_count),
		.pending_words  (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one word after a random gap and hold it until it is taken.
	// Leave valid high on return, so a gapless next word never drops it.
	task automatic send_word(input cap_word_t w);
		int r;
		int gap;
		r = $urandom_range(0, 99);
		if (send_gapless || r < 50)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			cap_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cap_valid <= 1'b1;
		cap       <= w;
		@(posedge clk);
		while (cap_stall) @(posedge clk);
	endtask

	task automatic edge_at(input bit rising, input logic [CNT_W-1:0] t);
		cap_word_t w;
		w.edge_rising  = rising;
		w.capture_time = t;
		send_word(w);
	endtask

	// Spread deltas over tiny, near-wrap, moderate and full-range values.
	function automatic logic [CNT_W-1:0] pick_delta();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return CNT_W'($urandom_range(0, 3));
		if (r < 32)
			return CNT_W'($urandom_range(65532, 65535));
		if (r < 60)
			return CNT_W'($urandom_range(4, 200));
		return CNT_W'($urandom);
	endfunction

	// Send one rise/fall/rise period with random timing. Sprinkle in
	// wrong-polarity edges the core must drop, and now and then a random
	// edge that may break the sequence.
	task automatic send_period();
		logic [CNT_W-1:0] t0;
		logic [CNT_W-1:0] dh;
		logic [CNT_W-1:0] dl;
		logic [CNT_W-1:0] t;
		int               r;
		t0 = CNT_W'($urandom);
		dh = pick_delta();
		dl = pick_delta();
		for (int k = 0; k < 3; k++) begin
			r = $urandom_range(0, 99);
			if (r < 12)
				edge_at(k == 1, CNT_W'($urandom));
			else if (r < 16)
				edge_at(1'($urandom_range(0, 1)), CNT_W'($urandom));
			t = t0;
			if (k >= 1)
				t = t + dh;
			if (k == 2)
				t = t + dl;
			edge_at(k != 1, t);
			words_sent++;
		end
	endtask

	// Drop valid, wait for every expected word, then let the core go quiet.
	task automatic settle();
		cap_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tick(input logic [TICK_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Result side: mostly short stalls, a few long ones, free-running
	// stretches, and the single long hold-off when asked for it.
	initial begin
		int n;
		int r;
		res_stall   = 1'b0;
		hold_served = 1'b0;
		forever begin
			r = $urandom_range(0, 99);
			if (hold_req && !hold_served) begin
				hold_served = 1'b1;
				res_stall <= 1'b1;
				n = HOLD_CYCLES;
			end else if (recv_free) begin
				res_stall <= 1'b0;
				n = 1;
			end else if (r < 60) begin
				res_stall <= 1'b0;
				n = $urandom_range(1, 8);
			end else if (r < 90) begin
				res_stall <= 1'b1;
				n = $urandom_range(1, 4);
			end else if (r < 97) begin
				res_stall <= 1'b1;
				n = $urandom_range(10, 40);
			end else begin
				res_stall <= 1'b0;
				n = $urandom_range(50, 150);
			end
			repeat (n) @(posedge clk);
		end
	end

	// Stop a hung run: count cycles with no handshake on either side.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cap_valid && !cap_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [TICK_W-1:0] tick_plan[NUM_RUNS];
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_data     = '0;
		cap_valid    = 1'b0;
		cap          = '0;
		send_gapless = 1'b0;
		recv_free    = 1'b0;
		hold_req     = 1'b0;
		words_sent   = 0;

		// A 16 MHz tick, the slowest tick, zero, all ones, a random rate, and
		// back to the reset rate.
		tick_plan[0] = TICK_W'(16000000);
		tick_plan[1] = TICK_W'(1);
		tick_plan[2] = '0;
		tick_plan[3] = '1;
		tick_plan[4] = TICK_W'($urandom_range(1, 16000000));
		tick_plan[5] = TICK_HZ_RESET;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset tick rate.
		// Drop a falling edge while seeking the first rise.
		edge_at(1'b0, 16'h1234);
		// Zero period, with a stray rise and a stray fall dropped on the way.
		edge_at(1'b1, 16'h0000);
		edge_at(1'b1, 16'h0005);
		edge_at(1'b0, 16'h0000);
		edge_at(1'b0, 16'h0009);
		edge_at(1'b1, 16'h0000);
		// Wrap in the high half: one tick high, 65535 low.
		edge_at(1'b1, 16'hFFFF);
		edge_at(1'b0, 16'h0000);
		edge_at(1'b1, 16'hFFFF);
		// Longest period: both halves at 65535.
		edge_at(1'b1, 16'h0000);
		edge_at(1'b0, 16'hFFFF);
		edge_at(1'b1, 16'hFFFE);
		// No high time: duty 0.
		edge_at(1'b1, 16'd100);
		edge_at(1'b0, 16'd100);
		edge_at(1'b1, 16'd200);
		// No low time: duty 100, one-tick period gives the full tick rate.
		edge_at(1'b1, 16'd5);
		edge_at(1'b0, 16'd6);
		edge_at(1'b1, 16'd6);
		// Rearm: the closing rise must not open the next period, so this
		// fall is dropped.
		edge_at(1'b0, 16'h7777);
		// Alternating bit patterns across the capture field.
		edge_at(1'b1, 16'h5555);
		edge_at(1'b0, 16'hAAAA);
		edge_at(1'b1, 16'hFFFF);
		edge_at(1'b1, 16'hAAAA);
		edge_at(1'b0, 16'h5555);
		edge_at(1'b1, 16'h0000);

		// Random runs, one per tick rate. Run 1 goes without any idling;
		// run 3 holds the result side off while edges keep coming, so the
		// output register fills and the core stalls its input.
		for (int p = 0; p < NUM_RUNS; p++) begin
			settle();
			write_tick(tick_plan[p]);
			send_gapless = (p == 1) || (p == 3);
			recv_free    = (p == 1);
			if (p == 3)
				hold_req = 1'b1;
			words_sent = 0;
			while (words_sent < WORDS_PER_RUN)
				send_period();
		end

		settle();
		if (mismatch_count == 0 && pending_words == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
